FILE: hdl/gasp_pkg.sv
`timescale 1ns / 1ps

package gasp_pkg;

  // Default sizes of the grid and of the open list.
  localparam int MAX_ROWS_DEF   = 8;
  localparam int MAX_COLS_DEF   = 8;
  localparam int HEAP_DEPTH_DEF = 256;

  // Longest walk back along the parent chain.
  localparam int MAX_RESULTS = 64;

  // Fixed field widths of the channels and the configuration port.
  localparam int COORD_W    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_USED  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_USED  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_ROW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_COL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_ROW = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_COL = 3'd5;

  // Input commands.
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  // Move directions, in the order they are tried.
  localparam logic [1:0] DIR_RIGHT = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_UP    = 2'd3;

  // Requests from the search sequencer to the open list.
  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } heap_ctl_t;

  // Status of the open list.
  typedef struct packed {
    logic done;
    logic dropped;
    logic empty;
  } heap_sts_t;

endpackage

FILE: hdl/gasp_if.sv
`timescale 1ns / 1ps

// Command channel: obstacle writes and search requests.
interface gasp_in_if import gasp_pkg::*;;
  logic               valid;
  logic               ready;
  logic               command;
  logic [COORD_W-1:0] cell_row;
  logic [COORD_W-1:0] cell_col;
  logic               blocked;

  modport source (output valid, command, cell_row, cell_col, blocked, input ready);
  modport sink   (input valid, command, cell_row, cell_col, blocked, output ready);
endinterface

// Result channel: one path cell per transfer.
interface gasp_out_if import gasp_pkg::*;;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] path_row;
  logic [COORD_W-1:0] path_col;
  logic               step_dir;
  logic               found;
  logic               heap_overflow;
  logic               last;

  modport source (output valid, path_row, path_col, step_dir, found, heap_overflow, last,
                  input ready);
  modport sink   (input valid, path_row, path_col, step_dir, found, heap_overflow, last,
                  output ready);
endinterface

FILE: hdl/gasp_heap.sv
`timescale 1ns / 1ps

module gasp_heap import gasp_pkg::*; #(
  parameter int HEAP_DEPTH = HEAP_DEPTH_DEF,
  parameter int KEY_W      = 13
) (
  input  logic             clk,
  input  logic             rst,
  input  heap_ctl_t        ctl,
  input  logic [KEY_W-1:0] push_key,
  output logic [KEY_W-1:0] pop_key,
  output heap_sts_t        sts
);

  localparam int HW   = $clog2(HEAP_DEPTH);
  localparam int CNTW = HW + 1;
  localparam int CHW  = HW + 2;

  typedef enum logic [2:0] {H_IDLE, H_UP, H_WR, H_POP, H_DN} hstate_t;

  logic [KEY_W-1:0] mem [HEAP_DEPTH];
  logic [KEY_W-1:0] rd0, rd1;
  logic [HW-1:0]    raddr0, raddr1, waddr;
  logic [KEY_W-1:0] wdata;
  logic             we;

  hstate_t          hstate, hstate_next;
  logic [CNTW-1:0]  cnt, cnt_next;
  logic [HW-1:0]    pos, pos_next;
  logic [KEY_W-1:0] key, key_next;
  logic [KEY_W-1:0] top, top_next;

  logic [HW-1:0]    par;
  logic [CHW-1:0]   lchild, rchild, mchild;
  logic             use_r;
  logic [KEY_W-1:0] mval;

  // Sift-up and sift-down sequencing, one level per cycle.
  always_comb begin
    hstate_next = hstate;
    cnt_next    = cnt;
    pos_next    = pos;
    key_next    = key;
    top_next    = top;
    we          = 1'b0;
    waddr       = pos;
    wdata       = key;
    raddr0      = '0;
    raddr1      = '0;
    sts         = '0;
    sts.empty   = (cnt == '0);
    par         = HW'((pos - HW'(1)) >> 1);
    lchild      = CHW'({pos, 1'b1});
    rchild      = lchild + CHW'(1);
    use_r       = (rchild < CHW'(cnt)) && (rd1 < rd0);
    mval        = use_r ? rd1 : rd0;
    mchild      = use_r ? rchild : lchild;
    case (hstate)
      H_IDLE: begin
        if (ctl.clear) begin
          cnt_next = '0;
        end else if (ctl.push) begin
          if (cnt == CNTW'(HEAP_DEPTH)) begin
            sts.done    = 1'b1;
            sts.dropped = 1'b1;
          end else if (cnt == '0) begin
            we       = 1'b1;
            waddr    = '0;
            wdata    = push_key;
            cnt_next = CNTW'(1);
            sts.done = 1'b1;
          end else begin
            pos_next    = HW'(cnt);
            key_next    = push_key;
            raddr0      = HW'((cnt - CNTW'(1)) >> 1);
            cnt_next    = cnt + CNTW'(1);
            hstate_next = H_UP;
          end
        end else if (ctl.pop) begin
          raddr0      = '0;
          raddr1      = HW'(cnt - CNTW'(1));
          cnt_next    = cnt - CNTW'(1);
          hstate_next = H_POP;
        end
      end
      H_UP: begin
        we = 1'b1;
        if (rd0 <= key) begin
          sts.done    = 1'b1;
          hstate_next = H_IDLE;
        end else begin
          wdata    = rd0;
          pos_next = par;
          if (par == '0) begin
            hstate_next = H_WR;
          end else begin
            raddr0 = HW'((par - HW'(1)) >> 1);
          end
        end
      end
      H_WR: begin
        we          = 1'b1;
        sts.done    = 1'b1;
        hstate_next = H_IDLE;
      end
      H_POP: begin
        top_next = rd0;
        if (cnt == '0) begin
          sts.done    = 1'b1;
          hstate_next = H_IDLE;
        end else begin
          key_next    = rd1;
          pos_next    = '0;
          raddr0      = HW'(1);
          raddr1      = HW'(2);
          hstate_next = H_DN;
        end
      end
      H_DN: begin
        we = 1'b1;
        if (lchild >= CHW'(cnt) || mval >= key) begin
          sts.done    = 1'b1;
          hstate_next = H_IDLE;
        end else begin
          wdata    = mval;
          pos_next = HW'(mchild);
          raddr0   = HW'({mchild, 1'b1});
          raddr1   = HW'({mchild, 1'b1} + (CHW + 1)'(1));
        end
      end
      default: hstate_next = H_IDLE;
    endcase
  end

  assign pop_key = (hstate == H_POP) ? rd0 : top;

  always_ff @(posedge clk) begin
    if (rst) begin
      hstate <= H_IDLE;
      cnt    <= '0;
    end else begin
      hstate <= hstate_next;
      cnt    <= cnt_next;
    end
    pos <= pos_next;
    key <= key_next;
    top <= top_next;
  end

  // Heap storage with two registered read ports.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd0 <= mem[raddr0];
    rd1 <= mem[raddr1];
  end

endmodule

FILE: hdl/grid_a_star_path_search_unit.sv
`timescale 1ns / 1ps

// Channel   Dir  Contents
// in_item   in   command, cell_row, cell_col, blocked
// result    out  path_row, path_col, step_dir, found, heap_overflow, last
// cfg_*     in   write enable, register index, data
//
// An obstacle write leaves the block idle; the next command is taken in the next cycle.
// A search holds in_item.ready low until its last result has entered the output register.
// Each pop passes through S_POP, S_POPW, S_CURRD and S_CUR; each neighbor through S_NBR
// and S_EVAL, then S_PUSH if it improves. Each walk step passes S_WRD, S_WALK and S_EMIT.
// The open list memory, with one write and two reads per cycle, sets the search time.
// Reset is synchronous and needs no clearing pass; a stalled result holds the walk.

module grid_a_star_path_search_unit import gasp_pkg::*; #(
  parameter int MAX_ROWS   = MAX_ROWS_DEF,
  parameter int MAX_COLS   = MAX_COLS_DEF,
  parameter int HEAP_DEPTH = HEAP_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  gasp_in_if.sink               in_item,
  gasp_out_if.source            result
);

  localparam int RW     = $clog2(MAX_ROWS);
  localparam int CLW    = $clog2(MAX_COLS);
  localparam int NCELLS = MAX_ROWS * MAX_COLS;
  localparam int CIW    = $clog2(NCELLS);
  localparam int CW     = $clog2(NCELLS + MAX_ROWS + MAX_COLS);
  localparam int KW     = CW + RW + CLW;
  localparam int RCW    = $clog2(MAX_ROWS + 1);
  localparam int CCW    = $clog2(MAX_COLS + 1);
  localparam int NW     = $clog2(MAX_RESULTS);

  typedef enum logic [3:0] {
    S_IDLE, S_PUSH, S_POP, S_POPW, S_CURRD, S_CUR, S_NBR, S_EVAL, S_WRD, S_WALK, S_EMIT
  } state_t;

  function automatic logic [CIW-1:0] cidx(input logic [RW-1:0] r, input logic [CLW-1:0] c);
    return CIW'(32'(r) * MAX_COLS + 32'(c));
  endfunction

  function automatic logic [CW-1:0] adiff(input logic [CW-1:0] a, input logic [CW-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // Configuration registers.
  logic [CFG_DATA_W-1:0] rows_used, cols_used;
  logic [COORD_W-1:0]    start_row, start_col, target_row, target_col;

  // Grid stores: obstacle flags, and cost with parent direction.
  logic              obst_mem [NCELLS];
  logic [CW+1:0]     grid_mem [NCELLS];
  logic [NCELLS-1:0] obst_vld;
  logic [NCELLS-1:0] known;
  logic              obst_rd;
  logic [CW+1:0]     grid_rd;
  logic              grid_we;
  logic [CIW-1:0]    grid_waddr, grid_raddr;
  logic [CW+1:0]     grid_wdata;
  logic              obst_we;
  logic [CIW-1:0]    obst_waddr;

  // Sequencer registers.
  state_t             state, e_ret;
  logic [RW-1:0]      cr, wr;
  logic [CLW-1:0]     cc, wc;
  logic [CW-1:0]      cost_cur;
  logic [1:0]         dsel;
  logic [NW-1:0]      wn;
  logic               ovf;
  logic [KW-1:0]      push_key;
  logic [COORD_W-1:0] e_row, e_col;
  logic               e_dir, e_found, e_last;
  logic               out_valid;
  logic [COORD_W-1:0] o_row, o_col;
  logic               o_dir, o_found, o_ovf, o_last;

  // Derived values.
  logic [RCW-1:0]  rows_eff;
  logic [CCW-1:0]  cols_eff;
  logic [RW-1:0]   sr, tr, nr, pr;
  logic [CLW-1:0]  sc, tc, nc, pc;
  logic            coords_bad, nvalid, improve, walk_last, cell_ok, search_go;
  logic [CIW-1:0]  nidx;
  logic [CW-1:0]   ncost, fval;
  logic [1:0]      wdir;

  heap_ctl_t        heap_ctl;
  heap_sts_t        heap_sts;
  logic [KW-1:0]    pop_key;

  gasp_heap #(.HEAP_DEPTH(HEAP_DEPTH), .KEY_W(KW)) u_heap (
    .clk      (clk),
    .rst      (rst),
    .ctl      (heap_ctl),
    .push_key (push_key),
    .pop_key  (pop_key),
    .sts      (heap_sts)
  );

  // Used grid size, clamped to one and to the maximum.
  always_comb begin
    if (rows_used == '0) begin
      rows_eff = RCW'(1);
    end else if (32'(rows_used) > MAX_ROWS) begin
      rows_eff = RCW'(MAX_ROWS);
    end else begin
      rows_eff = RCW'(rows_used);
    end
    if (cols_used == '0) begin
      cols_eff = CCW'(1);
    end else if (32'(cols_used) > MAX_COLS) begin
      cols_eff = CCW'(MAX_COLS);
    end else begin
      cols_eff = CCW'(cols_used);
    end
  end

  assign sr = RW'(start_row);
  assign sc = CLW'(start_col);
  assign tr = RW'(target_row);
  assign tc = CLW'(target_col);
  assign coords_bad = (32'(start_row) >= 32'(rows_eff)) || (32'(start_col) >= 32'(cols_eff)) ||
                      (32'(target_row) >= 32'(rows_eff)) || (32'(target_col) >= 32'(cols_eff));
  assign cell_ok = (32'(in_item.cell_row) < MAX_ROWS) && (32'(in_item.cell_col) < MAX_COLS);
  assign in_item.ready = (state == S_IDLE);
  assign search_go = in_item.valid && (state == S_IDLE) && (in_item.command == CMD_SEARCH);

  // Neighbor of the expanded cell in the current direction.
  always_comb begin
    nr     = cr;
    nc     = cc;
    nvalid = 1'b0;
    case (dsel)
      DIR_RIGHT: begin
        nvalid = (32'(cc) + 1) < 32'(cols_eff);
        nc     = cc + CLW'(1);
      end
      DIR_DOWN: begin
        nvalid = (32'(cr) + 1) < 32'(rows_eff);
        nr     = cr + RW'(1);
      end
      DIR_LEFT: begin
        nvalid = (cc != '0);
        nc     = cc - CLW'(1);
      end
      DIR_UP: begin
        nvalid = (cr != '0);
        nr     = cr - RW'(1);
      end
      default: nvalid = 1'b0;
    endcase
  end

  assign nidx    = cidx(nr, nc);
  assign ncost   = cost_cur + CW'(1);
  assign fval    = ncost + adiff(CW'(nr), CW'(tr)) + adiff(CW'(nc), CW'(tc));
  assign improve = !(obst_vld[nidx] && obst_rd) &&
                   (!known[nidx] || ncost < grid_rd[CW+1:2]);

  // Predecessor of the walk cell, undoing its parent move.
  assign wdir = grid_rd[1:0];
  always_comb begin
    pr = wr;
    pc = wc;
    case (wdir)
      DIR_RIGHT: pc = wc - CLW'(1);
      DIR_DOWN:  pr = wr - RW'(1);
      DIR_LEFT:  pc = wc + CLW'(1);
      DIR_UP:    pr = wr + RW'(1);
      default:   pr = wr;
    endcase
  end
  assign walk_last = ((pr == sr) && (pc == sc)) || (wn == NW'(MAX_RESULTS - 1));

  // Memory port selection and open-list requests.
  always_comb begin
    grid_we    = 1'b0;
    grid_waddr = nidx;
    grid_wdata = {ncost, dsel};
    grid_raddr = nidx;
    heap_ctl   = '0;
    obst_we    = 1'b0;
    obst_waddr = cidx(RW'(in_item.cell_row), CLW'(in_item.cell_col));
    case (state)
      S_IDLE: begin
        if (in_item.valid && in_item.command == CMD_WRITE && cell_ok) begin
          obst_we = 1'b1;
        end
        if (search_go) begin
          heap_ctl.clear = 1'b1;
          grid_we        = !coords_bad;
          grid_waddr     = cidx(sr, sc);
          grid_wdata     = '0;
        end
      end
      S_PUSH:  heap_ctl.push = 1'b1;
      S_POP:   heap_ctl.pop  = !heap_sts.empty;
      S_CURRD: grid_raddr = cidx(cr, cc);
      S_EVAL:  grid_we = improve;
      S_WRD:   grid_raddr = cidx(wr, wc);
      default: grid_we = 1'b0;
    endcase
  end

  // Grid memories with registered reads.
  always_ff @(posedge clk) begin
    if (obst_we) begin
      obst_mem[obst_waddr] <= in_item.blocked;
    end
    if (grid_we) begin
      grid_mem[grid_waddr] <= grid_wdata;
    end
    obst_rd <= obst_mem[nidx];
    grid_rd <= grid_mem[grid_raddr];
  end

  // Search sequencer, configuration and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      obst_vld   <= '0;
      known      <= '0;
      rows_used  <= CFG_DATA_W'(6);
      cols_used  <= CFG_DATA_W'(6);
      start_row  <= '0;
      start_col  <= '0;
      target_row <= COORD_W'(5);
      target_col <= COORD_W'(5);
      ovf        <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ROWS_USED:  rows_used  <= cfg_data;
          CFG_COLS_USED:  cols_used  <= cfg_data;
          CFG_START_ROW:  start_row  <= cfg_data[COORD_W-1:0];
          CFG_START_COL:  start_col  <= cfg_data[COORD_W-1:0];
          CFG_TARGET_ROW: target_row <= cfg_data[COORD_W-1:0];
          CFG_TARGET_COL: target_col <= cfg_data[COORD_W-1:0];
          default:        rows_used  <= rows_used;
        endcase
      end
      if (obst_we) begin
        obst_vld[obst_waddr] <= 1'b1;
      end
      // The output register loads a new result or empties after a transfer.
      if (state == S_EMIT && (!out_valid || result.ready)) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (search_go) begin
            ovf   <= 1'b0;
            if (coords_bad) begin
              known   <= '0;
              e_row   <= '0;
              e_col   <= '0;
              e_dir   <= 1'b0;
              e_found <= 1'b0;
              e_last  <= 1'b1;
              e_ret   <= S_IDLE;
              state   <= S_EMIT;
            end else begin
              known    <= NCELLS'(1) << cidx(sr, sc);
              push_key <= {CW'(0), sr, sc};
              dsel     <= DIR_UP;
              state    <= S_PUSH;
            end
          end
        end
        S_PUSH: begin
          if (heap_sts.done) begin
            ovf <= ovf | heap_sts.dropped;
            if (dsel == DIR_UP) begin
              state <= S_POP;
            end else begin
              dsel  <= dsel + 2'd1;
              state <= S_NBR;
            end
          end
        end
        S_POP: begin
          if (heap_sts.empty) begin
            e_row   <= '0;
            e_col   <= '0;
            e_dir   <= 1'b0;
            e_found <= 1'b0;
            e_last  <= 1'b1;
            e_ret   <= S_IDLE;
            state   <= S_EMIT;
          end else begin
            state <= S_POPW;
          end
        end
        S_POPW: begin
          if (heap_sts.done) begin
            cr <= pop_key[RW+CLW-1:CLW];
            cc <= pop_key[CLW-1:0];
            if (pop_key[RW+CLW-1:CLW] == tr && pop_key[CLW-1:0] == tc) begin
              wr <= tr;
              wc <= tc;
              wn <= '0;
              if (tr == sr && tc == sc) begin
                e_row   <= start_row;
                e_col   <= start_col;
                e_dir   <= 1'b0;
                e_found <= 1'b1;
                e_last  <= 1'b1;
                e_ret   <= S_IDLE;
                state   <= S_EMIT;
              end else begin
                state <= S_WRD;
              end
            end else begin
              state <= S_CURRD;
            end
          end
        end
        S_CURRD: state <= S_CUR;
        S_CUR: begin
          cost_cur <= grid_rd[CW+1:2];
          dsel     <= DIR_RIGHT;
          state    <= S_NBR;
        end
        S_NBR: begin
          if (nvalid) begin
            state <= S_EVAL;
          end else if (dsel == DIR_UP) begin
            state <= S_POP;
          end else begin
            dsel <= dsel + 2'd1;
          end
        end
        S_EVAL: begin
          if (improve) begin
            known[nidx] <= 1'b1;
            push_key    <= {fval, nr, nc};
            state       <= S_PUSH;
          end else if (dsel == DIR_UP) begin
            state <= S_POP;
          end else begin
            dsel  <= dsel + 2'd1;
            state <= S_NBR;
          end
        end
        S_WRD: state <= S_WALK;
        S_WALK: begin
          e_row   <= COORD_W'(pr);
          e_col   <= COORD_W'(pc);
          e_dir   <= wdir[0];
          e_found <= 1'b1;
          e_last  <= walk_last;
          e_ret   <= walk_last ? S_IDLE : S_WRD;
          wr      <= pr;
          wc      <= pc;
          wn      <= wn + NW'(1);
          state   <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid || result.ready) begin
            o_row     <= e_row;
            o_col     <= e_col;
            o_dir     <= e_dir;
            o_found   <= e_found;
            o_ovf     <= ovf;
            o_last    <= e_last;
            state     <= e_ret;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.valid         = out_valid;
  assign result.path_row      = o_row;
  assign result.path_col      = o_col;
  assign result.step_dir      = o_dir;
  assign result.found         = o_found;
  assign result.heap_overflow = o_ovf;
  assign result.last          = o_last;

  // A new search always starts from an empty open list.
  a_search_clears_heap: assert property (@(posedge clk) disable iff (rst)
    search_go |=> heap_sts.empty)
    else $error("open list not empty after search start");

  // A failed search ends in a single final result.
  a_fail_is_last: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.found) |-> result.last)
    else $error("result without a path is not final");

  // Every cell on the parent chain has a known cost.
  a_walk_known: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> known[cidx(wr, wc)])
    else $error("walk reached a cell with no cost");

  // Only neighbors inside the used grid are evaluated.
  a_eval_in_grid: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL) |-> (nvalid && $past(state) == S_NBR))
    else $error("neighbor outside grid evaluated");

endmodule

FILE: bench/gasp_path_checker.sv
`timescale 1ns / 1ps

module gasp_path_checker import gasp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  gasp_in_if                    in_mon,
  gasp_out_if                   res_mon,
  output int                    fail_count,
  output int                    pending
);

  localparam int NROWS  = MAX_ROWS_DEF;
  localparam int NCOLS  = MAX_COLS_DEF;
  localparam int NCELLS = NROWS * NCOLS;
  localparam int HDEPTH = HEAP_DEPTH_DEF;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               dir;
    logic               found;
    logic               ovf;
    logic               last;
  } path_cell_t;

  path_cell_t expected_cells[$];

  // Mirror of the obstacle map and of the configuration registers.
  logic        wall[NCELLS];
  logic [3:0]  rows_reg, cols_reg;
  logic [2:0]  srow_reg, scol_reg, trow_reg, tcol_reg;

  // Search scratch state.
  int          g_cost[NCELLS];
  logic        g_known[NCELLS];
  logic [1:0]  from_dir[NCELLS];
  int unsigned open_list[HDEPTH];
  int          open_cnt;
  logic        dropped;

  function automatic int dr(logic [1:0] d);
    return (d == DIR_DOWN) ? 1 : (d == DIR_UP) ? -1 : 0;
  endfunction

  function automatic int dc(logic [1:0] d);
    return (d == DIR_RIGHT) ? 1 : (d == DIR_LEFT) ? -1 : 0;
  endfunction

  function automatic void open_push(int unsigned key);
    int i;
    int p;
    if (open_cnt >= HDEPTH) begin
      dropped = 1'b1;
      return;
    end
    i = open_cnt;
    open_cnt++;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (open_list[p] <= key) break;
      open_list[i] = open_list[p];
      i = p;
    end
    open_list[i] = key;
  endfunction

  function automatic int unsigned open_pop();
    int unsigned top;
    int unsigned key;
    int i, l, r, m;
    top = open_list[0];
    i = 0;
    open_cnt--;
    if (open_cnt == 0) return top;
    key = open_list[open_cnt];
    forever begin
      l = 2 * i + 1;
      r = l + 1;
      if (l >= open_cnt) break;
      m = (r < open_cnt && open_list[r] < open_list[l]) ? r : l;
      if (open_list[m] >= key) break;
      open_list[i] = open_list[m];
      i = m;
    end
    open_list[i] = key;
    return top;
  endfunction

  function automatic void add_cell(int r, int c, logic dir, logic fnd, logic lst);
    path_cell_t e;
    e.row   = r[2:0];
    e.col   = c[2:0];
    e.dir   = dir;
    e.found = fnd;
    e.ovf   = dropped;
    e.last  = lst;
    expected_cells = {expected_cells, e};
  endfunction

  // Run A* on the mirrored map and queue the path cells it should produce.
  function automatic void predict_path();
    int rows, cols, sr, sc, tr, tc, r, c, nr, nc, ncost, h, cur, n, pr, pc;
    int unsigned key;
    logic fnd;
    logic [1:0] d;
    rows = (rows_reg == 0) ? 1 : (rows_reg > NROWS) ? NROWS : rows_reg;
    cols = (cols_reg == 0) ? 1 : (cols_reg > NCOLS) ? NCOLS : cols_reg;
    sr = srow_reg; sc = scol_reg; tr = trow_reg; tc = tcol_reg;
    for (int i = 0; i < NCELLS; i++) g_known[i] = 1'b0;
    open_cnt = 0;
    dropped  = 1'b0;
    fnd      = 1'b0;
    if (sr >= rows || sc >= cols || tr >= rows || tc >= cols) begin
      add_cell(0, 0, 1'b0, 1'b0, 1'b1);
      return;
    end
    g_known[sr * NCOLS + sc] = 1'b1;
    g_cost[sr * NCOLS + sc]  = 0;
    open_push((sr << 8) | sc);
    while (open_cnt > 0) begin
      key = open_pop();
      r = (key >> 8) & 8'hff;
      c = key & 8'hff;
      if (r >= rows || c >= cols) continue;
      if (r == tr && c == tc) begin
        fnd = 1'b1;
        break;
      end
      for (int k = 0; k < 4; k++) begin
        d  = k[1:0];
        nr = r + dr(d);
        nc = c + dc(d);
        if (nr < 0 || nc < 0 || nr >= rows || nc >= cols) continue;
        if (wall[nr * NCOLS + nc]) continue;
        ncost = g_cost[r * NCOLS + c] + 1;
        if (!g_known[nr * NCOLS + nc] || ncost < g_cost[nr * NCOLS + nc]) begin
          g_known[nr * NCOLS + nc] = 1'b1;
          g_cost[nr * NCOLS + nc]  = ncost;
          from_dir[nr * NCOLS + nc] = d;
          h = ((nr > tr) ? nr - tr : tr - nr) + ((nc > tc) ? nc - tc : tc - nc);
          open_push(((ncost + h) << 16) | (nr << 8) | nc);
        end
      end
    end
    if (!fnd) begin
      add_cell(0, 0, 1'b0, 1'b0, 1'b1);
      return;
    end
    if (sr == tr && sc == tc) begin
      add_cell(sr, sc, 1'b0, 1'b1, 1'b1);
      return;
    end
    // Walk the parent chain back from the target.
    n = 0;
    cur = tr * NCOLS + tc;
    while (cur != sr * NCOLS + sc && n < MAX_RESULTS) begin
      d  = from_dir[cur];
      pr = cur / NCOLS - dr(d);
      pc = cur % NCOLS - dc(d);
      add_cell(pr, pc, d[0], 1'b1, 1'b0);
      n++;
      if (pr < 0 || pc < 0 || pr >= NROWS || pc >= NCOLS) break;
      cur = pr * NCOLS + pc;
    end
    expected_cells[$].last = 1'b1;
  endfunction

  task automatic report_mismatch(string what, int want, int got);
    $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
    fail_count++;
  endtask

  // Track configuration and command transfers, and check each result transfer.
  always @(posedge clk) begin
    path_cell_t e;
    if (rst) begin
      for (int i = 0; i < NCELLS; i++) wall[i] = 1'b0;
      rows_reg = 4'd6; cols_reg = 4'd6;
      srow_reg = 3'd0; scol_reg = 3'd0;
      trow_reg = 3'd5; tcol_reg = 3'd5;
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ROWS_USED:  rows_reg = cfg_data;
          CFG_COLS_USED:  cols_reg = cfg_data;
          CFG_START_ROW:  srow_reg = cfg_data[2:0];
          CFG_START_COL:  scol_reg = cfg_data[2:0];
          CFG_TARGET_ROW: trow_reg = cfg_data[2:0];
          CFG_TARGET_COL: tcol_reg = cfg_data[2:0];
          default: ;
        endcase
      end
      if (res_mon.valid && res_mon.ready) begin
        if (expected_cells.size() == 0) begin
          report_mismatch("queued results", 0, 1);
        end else begin
          e = expected_cells.pop_front();
          if (res_mon.path_row !== e.row) report_mismatch("path_row", e.row, res_mon.path_row);
          if (res_mon.path_col !== e.col) report_mismatch("path_col", e.col, res_mon.path_col);
          if (res_mon.step_dir !== e.dir) report_mismatch("step_dir", e.dir, res_mon.step_dir);
          if (res_mon.found !== e.found) report_mismatch("found", e.found, res_mon.found);
          if (res_mon.heap_overflow !== e.ovf)
            report_mismatch("heap_overflow", e.ovf, res_mon.heap_overflow);
          if (res_mon.last !== e.last) report_mismatch("last", e.last, res_mon.last);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.command == CMD_WRITE)
          wall[in_mon.cell_row * NCOLS + in_mon.cell_col] = in_mon.blocked;
        else
          predict_path();
      end
    end
    pending = expected_cells.size();
  end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top import gasp_pkg::*; ();

  localparam int CYCLE_LIMIT = 2000000;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending;
  int                    cycles = 0;
  int                    gap_pct;
  int                    stall_pct;

  gasp_in_if  in_ch ();
  gasp_out_if res_ch ();

  grid_a_star_path_search_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_ch),
    .result    (res_ch)
  );

  gasp_path_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_mon     (in_ch),
    .res_mon    (res_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Clock with a 2 ns period.
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result receiver stalls at random.
  always @(posedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Guard against a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Offer one command and wait for its transfer; called right after a rising edge.
  task automatic send_cmd(logic cmd, logic [2:0] r, logic [2:0] c, logic blk);
    if ($urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.command  <= cmd;
    in_ch.cell_row <= r;
    in_ch.cell_col <= c;
    in_ch.blocked  <= blk;
    forever begin
      @(negedge clk);
      if (in_ch.ready) break;
    end
    @(posedge clk);
  endtask

  // Hold off until every expected result has arrived and the block has settled.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_grid(int rows, int cols, int sr, int sc, int tr, int tc);
    write_cfg(CFG_ROWS_USED, CFG_DATA_W'(rows));
    write_cfg(CFG_COLS_USED, CFG_DATA_W'(cols));
    write_cfg(CFG_START_ROW, CFG_DATA_W'(sr));
    write_cfg(CFG_START_COL, CFG_DATA_W'(sc));
    write_cfg(CFG_TARGET_ROW, CFG_DATA_W'(tr));
    write_cfg(CFG_TARGET_COL, CFG_DATA_W'(tc));
    @(posedge clk);
  endtask

  // Random round: new settings, a few obstacle writes, then a search.
  task automatic random_round();
    int rows, cols, nwr;
    if ($urandom_range(9) == 0) begin
      rows = $urandom_range(15);
      cols = $urandom_range(15);
    end else begin
      rows = $urandom_range(8, 2);
      cols = $urandom_range(8, 2);
    end
    wait_idle();
    if ($urandom_range(4) == 0)
      set_grid(rows, cols, $urandom_range(15), $urandom_range(15),
               $urandom_range(15), $urandom_range(15));
    else
      set_grid(rows, cols, $urandom_range(rows > 8 ? 7 : (rows == 0 ? 0 : rows - 1)),
               $urandom_range(cols > 8 ? 7 : (cols == 0 ? 0 : cols - 1)),
               $urandom_range(rows > 8 ? 7 : (rows == 0 ? 0 : rows - 1)),
               $urandom_range(cols > 8 ? 7 : (cols == 0 ? 0 : cols - 1)));
    nwr = $urandom_range(14, 4);
    for (int i = 0; i < nwr; i++)
      send_cmd(CMD_WRITE, 3'($urandom_range(7)), 3'($urandom_range(7)),
               $urandom_range(99) < 30);
    if ($urandom_range(7) == 0) begin
      // Pause the sender until the previous results have drained.
      wait_idle();
    end
    send_cmd(CMD_SEARCH, 3'($urandom_range(7)), 3'($urandom_range(7)),
             1'($urandom_range(1)));
  endtask

  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_ch.valid  = 1'b0;
    in_ch.command  = CMD_WRITE;
    in_ch.cell_row = '0;
    in_ch.cell_col = '0;
    in_ch.blocked  = 1'b0;
    gap_pct      = 11;
    stall_pct    = 50;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: search on reset settings over a free grid.
    send_cmd(CMD_SEARCH, 3'd0, 3'd0, 1'b0);
    // Start equals target at the far corner of a full grid.
    wait_idle();
    set_grid(8, 8, 7, 7, 7, 7);
    send_cmd(CMD_SEARCH, 3'd7, 3'd7, 1'b1);
    // Full grid corner to corner with a blocked start.
    wait_idle();
    set_grid(8, 8, 0, 0, 7, 7);
    send_cmd(CMD_WRITE, 3'd0, 3'd0, 1'b1);
    send_cmd(CMD_WRITE, 3'd7, 3'd0, 1'b1);
    send_cmd(CMD_SEARCH, 3'd0, 3'd0, 1'b0);
    // Blocked target.
    send_cmd(CMD_WRITE, 3'd7, 3'd7, 1'b1);
    send_cmd(CMD_SEARCH, 3'd0, 3'd0, 1'b0);
    // Wall across the grid makes the target unreachable, then a gap opens it.
    send_cmd(CMD_WRITE, 3'd7, 3'd7, 1'b0);
    for (int c = 0; c < 8; c++) send_cmd(CMD_WRITE, 3'd3, 3'(c), 1'b1);
    send_cmd(CMD_SEARCH, 3'd0, 3'd0, 1'b0);
    send_cmd(CMD_WRITE, 3'd3, 3'd6, 1'b0);
    send_cmd(CMD_SEARCH, 3'd0, 3'd0, 1'b0);
    // Target outside the used grid, and grid sizes of zero and fifteen.
    wait_idle();
    set_grid(4, 4, 0, 0, 5, 1);
    send_cmd(CMD_SEARCH, 3'd0, 3'd0, 1'b0);
    wait_idle();
    set_grid(0, 15, 0, 7, 0, 0);
    send_cmd(CMD_SEARCH, 3'd0, 3'd0, 1'b0);
    wait_idle();
    set_grid(15, 0, 7, 0, 0, 0);
    send_cmd(CMD_SEARCH, 3'd0, 3'd0, 1'b0);
    // Clear the wall again.
    for (int c = 0; c < 8; c++) send_cmd(CMD_WRITE, 3'd3, 3'(c), 1'b0);

    // Random rounds under the three idling profiles.
    for (int ph = 0; ph < 3; ph++) begin
      gap_pct   = (ph == 0) ? 11 : (ph == 1) ? 50 : 0;
      stall_pct = (ph == 0) ? 50 : (ph == 1) ? 11 : 0;
      for (int k = 0; k < 13; k++) random_round();
    end

    // Drain, then give the verdict.
    wait_idle();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
